/* rtl/bpra_pkg.sv */
// Shared constants, status codes and item types for the bitmap page run allocator.
// Used by the allocator top level, its busy-map memory and the port checker.
package bpra_pkg;

	localparam int MAX_REGIONS = 8;
	localparam int REGION_CAPACITY_PAGES = 256;
	localparam int PAGE_SHIFT = 12;

	localparam int ADDR_W = 48;
	localparam int SIZE_W = 21;
	localparam int NPAGE_W = 9;
	localparam int PAGES_W = 10;
	localparam int IDX_W = 3;
	localparam int HELD_W = 4;
	localparam int TOTAL_W = 12;
	localparam int BASE_W = ADDR_W - PAGE_SHIFT;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE = 2'd1;
	localparam logic [1:0] MODE_ADD = 2'd2;
	localparam logic [1:0] MODE_RELEASE = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_NO_ROOM = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_NO_MATCH = 3'd4;
	localparam logic [2:0] ST_OVERRUN = 3'd5;
	localparam logic [2:0] ST_TOO_LARGE = 3'd6;

	typedef struct packed {
		logic [1:0] mode;
		logic [SIZE_W-1:0] size_bytes;
		logic [ADDR_W-1:0] address;
		logic [NPAGE_W-1:0] region_pages;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [ADDR_W-1:0] address_out;
		logic [NPAGE_W-1:0] pages_wanted;
		logic [NPAGE_W-1:0] pages_minimum;
		logic [IDX_W-1:0] region_index;
		logic [TOTAL_W-1:0] held_pages;
	} out_item_t;

	// One operation on the busy-map memory per cycle.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic inv_one;
		logic inv_all;
		logic [IDX_W-1:0] addr;
	} mem_req_t;

endpackage

/* rtl/bitmap_page_run_allocator.sv */
// Bitmap first-fit page run allocator top level: sequencer, region table and result register.
// Depends on bpra_pkg and bpra_busy_mem.
//
// One item is handled at a time and in_stall stays high until its result is loaded into the
// output register. Add, release-all and early failures go straight to the done state. A free
// checks the held regions in turn for a match; if the run fits, it fetches the row, clears
// the pages one at a time and writes the row back. An alloc walks the held regions in order:
// it checks the size of each region, and for each region large enough it fetches the row,
// scans the bitmap bit by bit with the single run counter and then leaves the row. On a hit
// it sets the pages one at a time and writes the row back. The bit-serial run counter
// dominates the worst-case time.
module bitmap_page_run_allocator import bpra_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [NPAGE_W-1:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_A_NEXT = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_LOAD = 4'd3;
	localparam logic [3:0] S_SCAN = 4'd4;
	localparam logic [3:0] S_SET = 4'd5;
	localparam logic [3:0] S_WB = 4'd6;
	localparam logic [3:0] S_F_MATCH = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;
	logic [NPAGE_W-1:0] grain_q;
	logic [HELD_W-1:0] held_q;
	logic [TOTAL_W-1:0] total_q;
	logic [NPAGE_W-1:0] rsize_q [MAX_REGIONS];
	logic [BASE_W-1:0] rbase_q [MAX_REGIONS];

	logic [1:0] mode_q;
	logic [PAGES_W-1:0] pages_q;
	logic [BASE_W-1:0] apage_q;
	logic [HELD_W-1:0] ridx_q;
	logic [NPAGE_W-1:0] j_q;
	logic [NPAGE_W-1:0] run_q;
	logic [NPAGE_W-1:0] k_q;
	logic [PAGES_W-1:0] cnt_q;
	logic [REGION_CAPACITY_PAGES-1:0] row_q;

	logic [2:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [NPAGE_W-1:0] res_wanted_q;
	logic [NPAGE_W-1:0] res_min_q;
	logic [IDX_W-1:0] res_idx_q;

	logic out_valid_q;
	out_item_t out_q;

	mem_req_t mreq;
	logic [REGION_CAPACITY_PAGES-1:0] rd_data;

	logic [IDX_W-1:0] ri;
	logic [NPAGE_W-1:0] cur_size;
	logic [BASE_W-1:0] cur_base;
	logic [SIZE_W:0] size_round;
	logic [PAGES_W-1:0] in_pages;
	logic [NPAGE_W-1:0] run_n;
	logic [BASE_W:0] diff;
	logic in_region;
	logic [NPAGE_W-1:0] room;
	logic [NPAGE_W-1:0] wanted;
	logic regions_left;
	logic table_full;
	logic out_free;

	assign ri = ridx_q[IDX_W-1:0];
	assign cur_size = rsize_q[ri];
	assign cur_base = rbase_q[ri];
	assign size_round = {1'b0, in_item.size_bytes} + (SIZE_W+1)'((1 << PAGE_SHIFT) - 1);
	assign in_pages = size_round[SIZE_W:PAGE_SHIFT];
	assign run_n = row_q[j_q[7:0]] ? '0 : run_q + NPAGE_W'(1);
	assign diff = {1'b0, apage_q} - {1'b0, cur_base};
	assign in_region = !diff[BASE_W] && (diff[BASE_W-1:0] < BASE_W'(cur_size));
	assign room = cur_size - diff[NPAGE_W-1:0];
	assign regions_left = ridx_q < held_q;
	assign table_full = held_q >= HELD_W'(MAX_REGIONS);
	assign wanted = (pages_q > PAGES_W'(grain_q)) ? pages_q[NPAGE_W-1:0] :
		((grain_q > NPAGE_W'(REGION_CAPACITY_PAGES)) ? NPAGE_W'(REGION_CAPACITY_PAGES) : grain_q);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// Memory request for the current sequencer step.
	always_comb begin
		mreq = '0;
		mreq.addr = ri;
		case (state_q)
			S_RD: mreq.rd_en = 1'b1;
			S_WB: mreq.wr_en = 1'b1;
			S_IDLE: begin
				if (in_valid && in_item.mode == MODE_RELEASE) begin
					mreq.inv_all = 1'b1;
				end else if (in_valid && in_item.mode == MODE_ADD && in_item.region_pages != '0
						&& in_item.region_pages <= NPAGE_W'(REGION_CAPACITY_PAGES) && !table_full) begin
					mreq.inv_one = 1'b1;
					mreq.addr = held_q[IDX_W-1:0];
				end
			end
			default: ;
		endcase
	end

	bpra_busy_mem u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.wr_data(row_q),
		.rd_data(rd_data)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grain_q <= NPAGE_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			grain_q <= cfg_data;
		end
	end

	// Region base pages are written by an add and read only for held regions.
	always_ff @(posedge clk) begin
		if (mreq.inv_one) begin
			rbase_q[held_q[IDX_W-1:0]] <= in_item.address[ADDR_W-1:PAGE_SHIFT];
		end
	end

	// Working registers of the sequencer; payload only, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= in_item.mode;
				pages_q <= in_pages;
				apage_q <= in_item.address[ADDR_W-1:PAGE_SHIFT];
				ridx_q <= '0;
				res_status_q <= ST_OK;
				res_addr_q <= '0;
				res_wanted_q <= '0;
				res_min_q <= '0;
				res_idx_q <= '0;
				if (in_item.mode == MODE_ALLOC) begin
					if (in_pages == '0) begin
						res_status_q <= ST_ZERO;
					end else if (in_pages > PAGES_W'(REGION_CAPACITY_PAGES)) begin
						res_status_q <= ST_TOO_LARGE;
					end
				end else if (in_item.mode == MODE_FREE) begin
					if (in_pages == '0) begin
						res_status_q <= ST_ZERO;
					end else begin
						res_status_q <= ST_NO_MATCH;
					end
				end else if (in_item.mode == MODE_ADD) begin
					if (in_item.region_pages == '0) begin
						res_status_q <= ST_ZERO;
					end else if (in_item.region_pages > NPAGE_W'(REGION_CAPACITY_PAGES)) begin
						res_status_q <= ST_TOO_LARGE;
					end else if (table_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_idx_q <= held_q[IDX_W-1:0];
					end
				end
			end
			S_A_NEXT: begin
				if (!regions_left) begin
					if (table_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_NO_ROOM;
						res_wanted_q <= wanted;
						res_min_q <= pages_q[NPAGE_W-1:0];
					end
				end else if (pages_q > PAGES_W'(cur_size)) begin
					ridx_q <= ridx_q + HELD_W'(1);
				end
			end
			S_LOAD: begin
				row_q <= rd_data;
				j_q <= '0;
				run_q <= '0;
			end
			S_SCAN: begin
				if (j_q >= cur_size) begin
					ridx_q <= ridx_q + HELD_W'(1);
				end else if ({1'b0, run_n} == pages_q) begin
					k_q <= j_q + NPAGE_W'(1) - pages_q[NPAGE_W-1:0];
					cnt_q <= pages_q;
					res_addr_q <= {cur_base + BASE_W'(j_q + NPAGE_W'(1) - pages_q[NPAGE_W-1:0]),
						PAGE_SHIFT'(0)};
					res_idx_q <= ri;
				end else begin
					run_q <= run_n;
					j_q <= j_q + NPAGE_W'(1);
				end
			end
			S_SET: begin
				row_q[k_q[7:0]] <= (mode_q == MODE_ALLOC);
				k_q <= k_q + NPAGE_W'(1);
				cnt_q <= cnt_q - PAGES_W'(1);
			end
			S_F_MATCH: begin
				if (regions_left) begin
					if (in_region) begin
						res_idx_q <= ri;
						k_q <= diff[NPAGE_W-1:0];
						cnt_q <= pages_q;
						if (pages_q <= PAGES_W'(room)) begin
							res_status_q <= ST_OK;
						end else begin
							res_status_q <= ST_OVERRUN;
						end
					end else begin
						ridx_q <= ridx_q + HELD_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer, region table and held totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			total_q <= '0;
			for (int r = 0; r < MAX_REGIONS; r++) begin
				rsize_q[r] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DONE;
						if (mreq.inv_all) begin
							held_q <= '0;
							total_q <= '0;
							for (int r = 0; r < MAX_REGIONS; r++) begin
								rsize_q[r] <= '0;
							end
						end else if (mreq.inv_one) begin
							rsize_q[held_q[IDX_W-1:0]] <= in_item.region_pages;
							held_q <= held_q + HELD_W'(1);
							total_q <= total_q + TOTAL_W'(in_item.region_pages);
						end else if (in_item.mode == MODE_ALLOC && in_pages != '0
								&& in_pages <= PAGES_W'(REGION_CAPACITY_PAGES)) begin
							state_q <= S_A_NEXT;
						end else if (in_item.mode == MODE_FREE && in_pages != '0) begin
							state_q <= S_F_MATCH;
						end
					end
				end
				S_A_NEXT: begin
					if (!regions_left) begin
						state_q <= S_DONE;
					end else if (pages_q <= PAGES_W'(cur_size)) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_LOAD;
				S_LOAD: state_q <= (mode_q == MODE_ALLOC) ? S_SCAN : S_SET;
				S_SCAN: begin
					if (j_q >= cur_size) begin
						state_q <= S_A_NEXT;
					end else if ({1'b0, run_n} == pages_q) begin
						state_q <= S_SET;
					end
				end
				S_SET: begin
					if (cnt_q == PAGES_W'(1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: state_q <= S_DONE;
				S_F_MATCH: begin
					if (!regions_left) begin
						state_q <= S_DONE;
					end else if (in_region) begin
						state_q <= (pages_q <= PAGES_W'(room)) ? S_RD : S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.status <= res_status_q;
			out_q.address_out <= res_addr_q;
			out_q.pages_wanted <= res_wanted_q;
			out_q.pages_minimum <= res_min_q;
			out_q.region_index <= res_idx_q;
			out_q.held_pages <= total_q;
		end
	end

endmodule

/* rtl/bpra_busy_mem.sv */
// Busy-map memory: one 256-bit row per region with a valid bit per row.
// Depends on bpra_pkg for the request struct and sizes.
module bpra_busy_mem import bpra_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mem_req_t req,
	input logic [REGION_CAPACITY_PAGES-1:0] wr_data,
	output logic [REGION_CAPACITY_PAGES-1:0] rd_data
);

	logic [REGION_CAPACITY_PAGES-1:0] mem [MAX_REGIONS];
	logic [REGION_CAPACITY_PAGES-1:0] rd_q;
	logic [MAX_REGIONS-1:0] vld_q;
	logic rd_vld_q;

	// Row storage and registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.addr];
		end
	end

	// Row valid bits; an invalid row reads as all clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.addr];
			end
			if (req.inv_all) begin
				vld_q <= '0;
			end else if (req.inv_one) begin
				vld_q[req.addr] <= 1'b0;
			end else if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* rtl/bpra_checker.sv */
// Port-level checks for the bitmap page run allocator, bound to its top level.
// Depends on bpra_pkg for the item types and status codes.
module bpra_checker import bpra_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_item
);

	// A stalled result item holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// Only a successful alloc carries an address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.address_out == '0)
		else $error("address given on a failed item");

	// A no-room result asks for at least the pages requested.
	a_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_NO_ROOM |->
		out_item.pages_minimum != '0 && out_item.pages_wanted >= out_item.pages_minimum)
		else $error("bad region request on no-room result");

	// An accepted item is followed by a busy input side.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is still in work");

endmodule

bind bitmap_page_run_allocator bpra_checker u_bpra_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item(out_item)
);

/* tb/tb_bitmap_page_run_allocator.sv */
// Self-checking testbench for the bitmap page run allocator: random and directed items,
// predicted results from a behavioral copy of the region table. Depends on bpra_pkg and the RTL.
module tb_bitmap_page_run_allocator;
	import bpra_pkg::*;

	// Tracks region table state and queues the results each accepted item should produce.
	class alloc_scoreboard;
		bit busy [MAX_REGIONS][REGION_CAPACITY_PAGES];
		logic [BASE_W-1:0] base_page [MAX_REGIONS];
		int unsigned reg_size [MAX_REGIONS];
		int unsigned held;
		int unsigned grain;
		out_item_t pending [$];
		int errors;

		function new();
			errors = 0;
			grain = 64;
			drop_all();
		endfunction

		function void drop_all();
			foreach (busy[i, j]) busy[i][j] = 0;
			foreach (reg_size[i]) begin
				reg_size[i] = 0;
				base_page[i] = '0;
			end
			held = 0;
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			int unsigned pages, run, start, apage_off, want;
			logic [BASE_W-1:0] apage;
			bit found;
			r = '0;
			pages = (int'(it.size_bytes) + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
			r.status = ST_OK;
			case (it.mode)
				MODE_ALLOC: begin
					if (pages == 0) r.status = ST_ZERO;
					else if (pages > REGION_CAPACITY_PAGES) r.status = ST_TOO_LARGE;
					else begin
						found = 0;
						for (int i = 0; i < held && !found; i++) begin
							if (pages > reg_size[i]) continue;
							run = 0;
							for (int j = 0; j < reg_size[i] && !found; j++) begin
								run = busy[i][j] ? 0 : run + 1;
								if (run == pages) begin
									start = j + 1 - pages;
									found = 1;
									for (int k = start; k < start + pages; k++) busy[i][k] = 1;
									r.address_out = {base_page[i] + BASE_W'(start),
										PAGE_SHIFT'(0)};
									r.region_index = IDX_W'(i);
								end
							end
						end
						if (!found) begin
							if (held >= MAX_REGIONS) r.status = ST_FULL;
							else begin
								r.status = ST_NO_ROOM;
								want = pages > grain ? pages : grain;
								if (want > REGION_CAPACITY_PAGES) want = REGION_CAPACITY_PAGES;
								r.pages_wanted = NPAGE_W'(want);
								r.pages_minimum = NPAGE_W'(pages);
							end
						end
					end
				end
				MODE_FREE: begin
					if (pages == 0) r.status = ST_ZERO;
					else begin
						apage = it.address[ADDR_W-1:PAGE_SHIFT];
						r.status = ST_NO_MATCH;
						found = 0;
						for (int i = 0; i < held && !found; i++) begin
							if (apage < base_page[i] || apage - base_page[i] >= reg_size[i]) continue;
							found = 1;
							apage_off = 32'(apage - base_page[i]);
							r.region_index = IDX_W'(i);
							if (pages <= reg_size[i] - apage_off) begin
								for (int k = apage_off; k < apage_off + pages; k++) busy[i][k] = 0;
								r.status = ST_OK;
							end else r.status = ST_OVERRUN;
						end
					end
				end
				MODE_ADD: begin
					if (it.region_pages == 0) r.status = ST_ZERO;
					else if (it.region_pages > REGION_CAPACITY_PAGES) r.status = ST_TOO_LARGE;
					else if (held >= MAX_REGIONS) r.status = ST_FULL;
					else begin
						base_page[held] = it.address[ADDR_W-1:PAGE_SHIFT];
						reg_size[held] = it.region_pages;
						for (int k = 0; k < REGION_CAPACITY_PAGES; k++) busy[held][k] = 0;
						r.region_index = IDX_W'(held);
						held++;
					end
				end
				default: drop_all();
			endcase
			begin
				int unsigned sum;
				sum = 0;
				for (int i = 0; i < held; i++) sum += reg_size[i];
				r.held_pages = TOTAL_W'(sum);
			end
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status)
				$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
			if (got.address_out !== exp.address_out)
				$display("%0t: address_out exp %h got %h", $time, exp.address_out, got.address_out);
			if (got.pages_wanted !== exp.pages_wanted)
				$display("%0t: pages_wanted exp %0d got %0d", $time, exp.pages_wanted, got.pages_wanted);
			if (got.pages_minimum !== exp.pages_minimum)
				$display("%0t: pages_minimum exp %0d got %0d", $time, exp.pages_minimum,
					got.pages_minimum);
			if (got.region_index !== exp.region_index)
				$display("%0t: region_index exp %0d got %0d", $time, exp.region_index,
					got.region_index);
			if (got.held_pages !== exp.held_pages)
				$display("%0t: held_pages exp %0d got %0d", $time, exp.held_pages, got.held_pages);
			if (got !== exp) errors++;
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_item;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [NPAGE_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	alloc_scoreboard sb;

	bitmap_page_run_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Receiver: random stall, check each accepted result.
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);
	end

	// Watchdog on cycles with no accepted item of any kind.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Drives one item and waits for its acceptance; the item is noted when accepted.
	// The block stalls after an accepted item, so the extra falling edge at the start costs
	// no throughput.
	task automatic send_item(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_item <= it;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic send_op(logic [1:0] m, int unsigned sz, logic [ADDR_W-1:0] a, int unsigned rp);
		in_item_t it;
		it.mode = m;
		it.size_bytes = SIZE_W'(sz);
		it.address = a;
		it.region_pages = NPAGE_W'(rp);
		send_item(it);
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_grain(int unsigned g);
		wait_drained();
		cfg_data <= NPAGE_W'(g);
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.grain = g & 32'h1FF;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Random item biased toward well-formed adds, allocs and frees of live runs.
	task automatic random_item(ref logic [ADDR_W-1:0] live_addr [$], ref int unsigned live_sz [$]);
		int unsigned pick, k;
		in_item_t it;
		pick = $urandom_range(99);
		it.address = ADDR_W'({$urandom, $urandom});
		it.size_bytes = SIZE_W'($urandom);
		it.region_pages = NPAGE_W'($urandom);
		if (pick < 12) begin
			it.mode = MODE_ADD;
			it.region_pages = ($urandom_range(9) == 0) ? NPAGE_W'($urandom) :
				NPAGE_W'($urandom_range(256, 1));
			if ($urandom_range(1)) it.address[ADDR_W-1:20] = 28'($urandom_range(7));
		end else if (pick < 55) begin
			it.mode = MODE_ALLOC;
			if ($urandom_range(9) != 0) it.size_bytes = SIZE_W'($urandom_range(64 << PAGE_SHIFT));
			if (it.size_bytes > (256 << PAGE_SHIFT)) it.size_bytes = SIZE_W'(256 << PAGE_SHIFT);
		end else if (pick < 90 && live_addr.size() != 0) begin
			it.mode = MODE_FREE;
			k = $urandom_range(live_addr.size() - 1);
			it.address = live_addr[k] | ADDR_W'($urandom_range(4095));
			it.size_bytes = SIZE_W'(live_sz[k]);
			live_addr.delete(k);
			live_sz.delete(k);
		end else if (pick < 97) begin
			it.mode = MODE_FREE;
		end else begin
			it.mode = MODE_RELEASE;
			live_addr.delete();
			live_sz.delete();
		end
		send_item(it);
		if (it.mode == MODE_ALLOC && sb.pending[$].status == ST_OK) begin
			live_addr.push_back(sb.pending[$].address_out);
			live_sz.push_back(it.size_bytes);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] live_addr [$];
		int unsigned live_sz [$];
		int idle_cfg [4][2];
		sb = new();
		idle_cfg = '{'{0, 0}, '{83, 0}, '{0, 83}, '{22, 22}};
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, each mode and each special case.
		send_op(MODE_ALLOC, 4096, 0, 1);                     // no room, reset grain
		send_op(MODE_ALLOC, 0, 0, 1);                        // zero size alloc
		send_op(MODE_ALLOC, 257 << PAGE_SHIFT, 0, 1);        // too large
		send_op(MODE_ALLOC, 1048576, 0, 1);
		send_op(MODE_ADD, 0, 48'h0000_0010_0fff, 0);         // zero-page add
		send_op(MODE_ADD, 0, 48'h0000_0010_0000, 511);       // oversize add
		send_op(MODE_ADD, 0, 48'h0000_0010_0abc, 4);
		send_op(MODE_ADD, 0, 48'hffff_ffff_f000 - (255 << 12), 256);
		send_op(MODE_ALLOC, 1, 0, 0);
		send_op(MODE_ALLOC, 8192, 0, 0);
		send_op(MODE_ALLOC, 1048576, 0, 0);                  // whole second region
		send_op(MODE_FREE, 0, 48'h0000_0010_0000, 0);        // zero-size free
		send_op(MODE_FREE, 5 << 12, 48'h0000_0010_0000, 0);  // overrun
		send_op(MODE_FREE, 4096, 48'h0000_0000_0000, 0);     // outside all regions
		send_op(MODE_FREE, 4096, 48'h0000_0010_3000, 0);     // pages not busy
		send_op(MODE_FREE, 8192, 48'h0000_0010_1000, 0);
		for (int i = 0; i < 6; i++) send_op(MODE_ADD, 0, ADDR_W'((i + 64) << 20), 1);
		send_op(MODE_ADD, 0, 48'h0, 1);                      // table full on add
		send_op(MODE_ALLOC, 200 << 12, 0, 0);                // table full on alloc
		send_op(MODE_FREE, 4096, 48'hffff_ffff_ffff, 0);
		send_op(MODE_RELEASE, 0, 0, 0);

		write_grain(1);
		send_op(MODE_ALLOC, 4096, 0, 0);
		write_grain(256);
		send_op(MODE_ALLOC, 4096, 0, 0);

		// Random phases with rotating idle patterns and grain values.
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			send_idle_pct = idle_cfg[p % 4][0];
			recv_stall_pct = idle_cfg[p % 4][1];
			case (p % 4)
				0: write_grain(1);
				1: write_grain(256);
				2: write_grain($urandom);
				default: write_grain($urandom_range(256, 1));
			endcase
			for (int n = 0; n < 31; n++) random_item(live_addr, live_sz);
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		repeat (2500) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/bpra_pkg.sv
rtl/bpra_busy_mem.sv
rtl/bitmap_page_run_allocator.sv
rtl/bpra_checker.sv
tb/tb_bitmap_page_run_allocator.sv
